// ===== hdl/optt_pkg.sv =====
// Package for the transmit operation tracker table.
// Holds opcodes, status codes, flag bits and the entry record type.
// No dependencies.
package optt_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int CAP_W = 4;

   typedef enum logic [2:0] {
      OP_RETAIN    = 3'd0,
      OP_REMOVE    = 3'd1,
      OP_RETIRE    = 3'd2,
      OP_TRANSLATE = 3'd3,
      OP_CLEAR     = 3'd4
   } op_code_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_code_type;

   localparam int FLAG_IND     = 0;
   localparam int FLAG_SENT    = 1;
   localparam int FLAG_RETIRED = 2;

   localparam logic [3:0] KIND_NOTIFY   = 4'd0;
   localparam logic [3:0] KIND_INDICATE = 4'd1;

   typedef struct packed {
      logic [15:0] conn;
      logic [15:0] value;
      logic [3:0]  kind;
      logic [31:0] generation;
      logic [31:0] token;
      logic [2:0]  flags;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Result of comparing one entry against the current request.
   typedef struct packed {
      logic ident_hit;
      logic dup_hit;
      logic xlate_hit;
   } cmp_type;

endpackage

// ===== hdl/tx_operation_tracker_table.sv =====
// Transmit operation tracker table: ordered list of pending transmit operations.
// Clear and rejected requests go straight to the response; a notification retain
// appends without a scan; other ops scan the entries in order up to the first hit,
// and a removal then shifts the later entries down one place, read then write.
// One op at a time: a result waits until taken before the next op is accepted.
// Reset (synchronous, active high) empties the table and sets capacity to 8;
// entry storage itself is not cleared.
module tx_operation_tracker_table
   import optt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_conn_hdl,
   input  logic [15:0] req_attr_hdl,
   input  logic        req_indication,
   input  logic        req_terminal,
   input  logic [3:0]  req_kind,
   input  logic [31:0] req_generation,
   input  logic [31:0] req_token,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_match_conn_hdl,
   output logic [3:0]  rsp_match_kind,
   output logic [31:0] rsp_match_generation,
   output logic [31:0] rsp_match_token,
   output logic [3:0]  rsp_entries_in_use,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_capacity_in_use
);
   localparam int CW = $clog2(DEPTH+1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_RESP
   } state_type;

   state_type   state_ff;
   logic [2:0]  op_ff;
   logic [15:0] conn_ff, value_ff;
   logic        ind_ff, term_ff;
   logic [3:0]  kind_ff;
   logic [31:0] gen_ff, tok_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic [3:0]  cap_ff;
   logic [2:0]  status_ff;
   entry_type   match_ff;
   logic        rsp_valid_ff;

   logic          wr_en;
   logic [CW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;
   cmp_type       cmp;
   logic [CW-1:0] cap_eff;
   logic          hit;

   optt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   optt_compare u_cmp (
      .entry(rd_data), .conn_hdl(conn_ff), .attr_hdl(value_ff),
      .indication(ind_ff), .terminal(term_ff), .kind(kind_ff),
      .generation(gen_ff), .token(tok_ff), .result(cmp)
   );

   // Effective capacity is the smaller of the register and DEPTH.
   always_comb begin
      if (int'(cap_ff) < DEPTH) begin
         cap_eff = CW'(cap_ff);
      end else begin
         cap_eff = CW'(DEPTH);
      end
   end

   // Hit for the operation in progress.
   always_comb begin
      unique case (op_code_type'(op_ff))
         OP_RETAIN:            hit = cmp.dup_hit;
         OP_REMOVE, OP_RETIRE: hit = cmp.ident_hit;
         OP_TRANSLATE:         hit = cmp.xlate_hit;
         default:              hit = 1'b0;
      endcase
   end

   // Memory port control: the scan reads idx first and then prefetches the next entry;
   // writes serve append, flag update and shift.
   always_comb begin
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      if (state_ff == S_CHECK || state_ff == S_SHIFT_RD) begin
         rd_addr = idx_ff + CW'(1);
      end
      if (state_ff == S_CHECK && op_ff == OP_RETAIN && idx_ff == count_ff &&
          count_ff < cap_eff) begin
         wr_en   = 1'b1;
         wr_data = '{conn: conn_ff, value: value_ff, kind: kind_ff,
                     generation: gen_ff, token: tok_ff,
                     flags: {2'b00, ind_ff}};
      end else if (state_ff == S_CHECK && hit && idx_ff < count_ff &&
                   (op_ff == OP_RETIRE ||
                    (op_ff == OP_TRANSLATE && ind_ff && !term_ff))) begin
         wr_en = 1'b1;
         wr_data.flags[FLAG_SENT] = 1'b1;
         if (op_ff == OP_RETIRE) begin
            wr_data.flags[FLAG_RETIRED] = 1'b1;
         end
      end else if (state_ff == S_SHIFT_WR) begin
         wr_en = 1'b1;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;

   // Sequencer: scan entries one per cycle, then act on the first hit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= 4'd8;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_capacity_in_use;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  op_ff    <= req_op;
                  conn_ff  <= req_conn_hdl;
                  value_ff <= req_attr_hdl;
                  ind_ff   <= req_indication;
                  term_ff  <= req_terminal;
                  kind_ff  <= req_kind;
                  gen_ff   <= req_generation;
                  tok_ff   <= req_token;
                  match_ff <= '0;
                  if (req_op == OP_CLEAR) begin
                     idx_ff    <= '0;
                     status_ff <= ST_OK;
                     count_ff  <= '0;
                     state_ff  <= S_RESP;
                  end else if (req_op > OP_CLEAR) begin
                     idx_ff    <= '0;
                     status_ff <= ST_INVALID;
                     state_ff  <= S_RESP;
                  end else if (req_op == OP_RETAIN &&
                               (req_generation == '0 || req_token == '0 ||
                                req_kind != (req_indication ? KIND_INDICATE
                                                            : KIND_NOTIFY))) begin
                     idx_ff    <= '0;
                     status_ff <= ST_INVALID;
                     state_ff  <= S_RESP;
                  end else if (req_op == OP_RETAIN && !req_indication) begin
                     idx_ff    <= count_ff;
                     status_ff <= ST_OK;
                     state_ff  <= S_CHECK;
                  end else begin
                     idx_ff    <= '0;
                     status_ff <= ST_OK;
                     state_ff  <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // Read data for idx is valid next cycle.
               state_ff <= S_CHECK;
               if (idx_ff >= count_ff) begin
                  idx_ff <= count_ff;
               end
            end
            S_CHECK: begin
               if (idx_ff >= count_ff) begin
                  if (op_ff == OP_RETAIN) begin
                     if (count_ff < cap_eff) begin
                        count_ff <= count_ff + CW'(1);
                     end else begin
                        status_ff <= ST_FULL;
                     end
                  end else begin
                     status_ff <= ST_NOT_FOUND;
                  end
                  state_ff <= S_RESP;
               end else if (hit) begin
                  if (op_ff == OP_RETAIN) begin
                     status_ff <= ST_DUPLICATE;
                     state_ff  <= S_RESP;
                  end else begin
                     if (op_ff == OP_TRANSLATE) begin
                        match_ff <= rd_data;
                     end
                     if (op_ff == OP_REMOVE ||
                         (op_ff == OP_TRANSLATE && !(ind_ff && !term_ff))) begin
                        state_ff <= S_SHIFT_RD;
                     end else begin
                        state_ff <= S_RESP;
                     end
                  end
               end else begin
                  // The next entry was prefetched; stay here until a hit or the end is reached.
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_SHIFT_RD: begin
               // Reading idx+1; written to idx next cycle.
               if (idx_ff + CW'(1) >= count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_SHIFT_WR;
               end
            end
            S_SHIFT_WR: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_SHIFT_RD;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_match_conn_hdl    = match_ff.conn;
   assign rsp_match_kind        = match_ff.kind;
   assign rsp_match_generation  = match_ff.generation;
   assign rsp_match_token       = match_ff.token;
   assign rsp_entries_in_use    = 4'(count_ff);
endmodule

// ===== hdl/optt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module optt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH+1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH+1)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   localparam int AW = $clog2(DEPTH+1);
   logic [WIDTH-1:0] mem [DEPTH];

   // Addresses are $clog2(DEPTH+1) bits so a counter can hold DEPTH; only low part indexes.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr < AW'(DEPTH))) begin
         mem[wr_addr[$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]] <= wr_data;
      end
      rd_data <= mem[rd_addr[$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]];
   end
endmodule

// ===== hdl/optt_compare.sv =====
// Shared comparison unit: matches one table entry against the request.
// Depends on optt_pkg.
module optt_compare
   import optt_pkg::*;
(
   input  entry_type   entry,
   input  logic [15:0] conn_hdl,
   input  logic [15:0] attr_hdl,
   input  logic        indication,
   input  logic        terminal,
   input  logic [3:0]  kind,
   input  logic [31:0] generation,
   input  logic [31:0] token,
   output cmp_type     result
);
   logic tuple_hit;

   // Identity, duplicate-indication and translate tuple matches.
   always_comb begin
      tuple_hit = (entry.conn == conn_hdl) && (entry.value == attr_hdl);
      result.ident_hit = (entry.conn == conn_hdl) && (entry.kind == kind) &&
                         (entry.generation == generation) && (entry.token == token);
      result.dup_hit   = tuple_hit && entry.flags[FLAG_IND];
      result.xlate_hit = tuple_hit && (entry.flags[FLAG_IND] == indication) &&
                         (!indication || terminal ||
                          (!entry.flags[FLAG_SENT] && !entry.flags[FLAG_RETIRED]));
   end
endmodule
